@@ rtl/core/fpv_pkg.sv @@
// Package: shared types, constants and CRC byte-update functions for the prefix validator.
`timescale 1ns / 1ps
package fpv_pkg;

  localparam int unsigned CountW      = 17;
  localparam int unsigned PrefixBytes = 12;
  localparam int unsigned MagicBytes  = 4;
  localparam int unsigned HdrCrcSpan  = 6;
  localparam int unsigned BitsPerByte = 8;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  localparam logic [15:0] Crc16Init  = 16'hFFFF;
  localparam logic [15:0] Crc16Poly  = 16'h1021;
  localparam logic [31:0] Crc32cInit = 32'hFFFF_FFFF;
  localparam logic [31:0] Crc32cPoly = 32'h82F6_3B78;
  localparam logic [31:0] Crc32cXor  = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_MAGIC = 3'd1,
    ST_BAD_HCRC = 3'd2,
    ST_LEN_OOB  = 3'd3,
    ST_BAD_BCRC = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    K_SKIP  = 3'd0,
    K_MAGIC = 3'd1,
    K_LEN   = 3'd2,
    K_HCRC  = 3'd3,
    K_BCRC  = 3'd4,
    K_BODY  = 3'd5
  } kind_e;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    logic [1:0] idx;
    logic       is_end;
    logic       short_frame;
    logic       len_oob;
  } cmd_t;

  function automatic logic [15:0] crc16_byte(logic [15:0] crc_in, logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < BitsPerByte; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ Crc16Poly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [31:0] crc32c_byte(logic [31:0] crc_in, logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'h0, b};
    for (int i = 0; i < BitsPerByte; i++) begin
      if (c[0]) begin
        c = {1'b0, c[31:1]} ^ Crc32cPoly;
      end else begin
        c = {1'b0, c[31:1]};
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/core/frame_prefix_validator_core.sv @@
// Top level: datagram prefix validator (magic, header CRC-16, length, body CRC-32C).
//
// Input stream s_axis: one datagram byte per word in tdata, tlast marks the final
// byte, tuser set means an empty end marker that carries no byte and closes the
// datagram. Output stream m_axis: one verdict word per datagram, tdata holds
// status, body length and body start. Byte-per-cycle throughput: one input word
// is taken every cycle while the two-entry queue is not full.
// The verdict word for a datagram reaches m_axis from the queue write of its final
// input word, then the back end's check into its output register; CRC updates are
// one byte per cycle in fixed logic while the back end pops queued words.
// The output register frees a slot in the same cycle it is taken, so a verdict
// being taken does not block a new one. When m_axis_tready stays low, the back end
// stops at the next end-of-datagram word, the queue fills and s_axis_tready drops.
// Reset clears frame state, the queue and the output valid; magic_word resets to
// 0. cfg_we_i writes magic_word (byte zero in bits 7:0); write only while idle.
`timescale 1ns / 1ps
module frame_prefix_validator_core import fpv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  input  logic        s_axis_tuser,   // empty_datagram
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [2:0] status, [18:3] body_length, [22:19] body_start
);

  logic [31:0] magic_q;
  cmd_t        front_cmd, head_cmd;
  logic        q_full, q_valid, q_pop, push;
  logic [2:0]  o_status;
  logic [15:0] o_len;
  logic [3:0]  o_start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q <= '0;
    end else if (cfg_we_i) begin
      magic_q <= cfg_wdata_i;
    end
  end

  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && !q_full;

  fpv_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_i (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .in_empty_i (s_axis_tuser),
    .cmd_o      (front_cmd)
  );

  fpv_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (front_cmd),
    .pop_i      (q_pop),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .head_o     (head_cmd)
  );

  fpv_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .magic_i      (magic_q),
    .cmd_valid_i  (q_valid),
    .cmd_i        (head_cmd),
    .pop_o        (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (o_status),
    .out_len_o    (o_len),
    .out_start_o  (o_start)
  );

  assign m_axis_tdata = {1'b0, o_start, o_len, o_status};

endmodule

@@ rtl/core/fpv_front.sv @@
// Front end: accepts bytes, tracks position and length, tags each word for the back end.
`timescale 1ns / 1ps
module fpv_front import fpv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] in_data_i,
  input  logic       in_last_i,
  input  logic       in_empty_i,
  output cmd_t       cmd_o
);

  logic [CountW-1:0] cnt_q, cnt_d;
  logic [15:0]       len_q, len_d;
  logic [CountW-1:0] cnt_inc, cnt_after, len_end;
  logic              take, fin;

  assign take    = in_valid_i && in_ready_i;
  assign fin     = in_empty_i || in_last_i;
  assign cnt_inc = (cnt_q == CountMax) ? cnt_q : cnt_q + CountW'(1);

  always_comb begin
    len_d = len_q;
    if (!in_empty_i && cnt_q == CountW'(MagicBytes)) begin
      len_d = {len_q[15:8], in_data_i};
    end else if (!in_empty_i && cnt_q == CountW'(MagicBytes + 1)) begin
      len_d = {in_data_i, len_q[7:0]};
    end
  end

  assign cnt_after = in_empty_i ? cnt_q : cnt_inc;
  assign len_end   = {1'b0, len_d} + CountW'(PrefixBytes);

  always_comb begin
    cmd_o             = '0;
    cmd_o.data        = in_data_i;
    cmd_o.kind        = K_SKIP;
    cmd_o.idx         = cnt_q[1:0];
    cmd_o.is_end      = fin;
    cmd_o.short_frame = cnt_after < CountW'(PrefixBytes);
    cmd_o.len_oob     = len_end > cnt_after;
    if (!in_empty_i) begin
      if (cnt_q < CountW'(MagicBytes)) begin
        cmd_o.kind = K_MAGIC;
      end else if (cnt_q < CountW'(HdrCrcSpan)) begin
        cmd_o.kind = K_LEN;
        cmd_o.idx  = {1'b0, cnt_q[0]};
      end else if (cnt_q < CountW'(8)) begin
        cmd_o.kind = K_HCRC;
        cmd_o.idx  = {1'b0, cnt_q[0]};
      end else if (cnt_q < CountW'(PrefixBytes)) begin
        cmd_o.kind = K_BCRC;
      end else if (cnt_q < {1'b0, len_q} + CountW'(PrefixBytes)) begin
        cmd_o.kind = K_BODY;
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (take) begin
      cnt_d = fin ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      len_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (take) begin
        len_q <= fin ? '0 : len_d;
      end
    end
  end

endmodule

@@ rtl/core/fpv_queue.sv @@
// Two-entry queue between the front and back ends.
`timescale 1ns / 1ps
module fpv_queue import fpv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  input  logic pop_i,
  output logic full_o,
  output logic valid_o,
  output cmd_t head_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;

  assign full_o  = fill_q == 2'd2;
  assign valid_o = fill_q != 2'd0;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

endmodule

@@ rtl/core/fpv_back.sv @@
// Back end: runs the magic, CRC and length checks and holds the verdict output register.
`timescale 1ns / 1ps
module fpv_back import fpv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] magic_i,
  input  logic        cmd_valid_i,
  input  cmd_t        cmd_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  out_status_o,
  output logic [15:0] out_len_o,
  output logic [3:0]  out_start_o
);

  logic        magic_ok_q, magic_ok_d;
  logic [15:0] len_q, len_d;
  logic [15:0] hfield_q, hfield_d;
  logic [31:0] bfield_q, bfield_d;
  logic [15:0] hcrc_q, hcrc_d;
  logic [31:0] bcrc_q, bcrc_d;
  logic [7:0]  exp_byte;
  logic        slot_free;
  status_e     verdict;

  logic        out_valid_q;
  status_e     status_q;
  logic [15:0] olen_q;
  logic [3:0]  ostart_q;

  assign slot_free = !out_valid_q || out_ready_i;
  assign pop_o     = cmd_valid_i && (!cmd_i.is_end || slot_free);
  assign exp_byte  = magic_i[8*cmd_i.idx +: 8];

  always_comb begin
    magic_ok_d = magic_ok_q;
    len_d      = len_q;
    hfield_d   = hfield_q;
    bfield_d   = bfield_q;
    hcrc_d     = hcrc_q;
    bcrc_d     = bcrc_q;
    case (cmd_i.kind)
      K_MAGIC: begin
        if (cmd_i.data != exp_byte) magic_ok_d = 1'b0;
        hcrc_d = crc16_byte(hcrc_q, cmd_i.data);
      end
      K_LEN: begin
        if (cmd_i.idx[0]) len_d = {cmd_i.data, len_q[7:0]};
        else              len_d = {len_q[15:8], cmd_i.data};
        hcrc_d = crc16_byte(hcrc_q, cmd_i.data);
      end
      K_HCRC: begin
        if (cmd_i.idx[0]) hfield_d = {cmd_i.data, hfield_q[7:0]};
        else              hfield_d = {hfield_q[15:8], cmd_i.data};
      end
      K_BCRC: bfield_d[8*cmd_i.idx +: 8] = cmd_i.data;
      K_BODY: bcrc_d = crc32c_byte(bcrc_q, cmd_i.data);
      default: ;
    endcase
  end

  always_comb begin
    if (cmd_i.short_frame || !magic_ok_d) begin
      verdict = ST_BAD_MAGIC;
    end else if (hcrc_d != hfield_d) begin
      verdict = ST_BAD_HCRC;
    end else if (cmd_i.len_oob) begin
      verdict = ST_LEN_OOB;
    end else if ((bcrc_d ^ Crc32cXor) != bfield_d) begin
      verdict = ST_BAD_BCRC;
    end else begin
      verdict = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_ok_q  <= 1'b1;
      len_q       <= '0;
      hfield_q    <= '0;
      bfield_q    <= '0;
      hcrc_q      <= Crc16Init;
      bcrc_q      <= Crc32cInit;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (pop_o) begin
        if (cmd_i.is_end) begin
          magic_ok_q  <= 1'b1;
          len_q       <= '0;
          hfield_q    <= '0;
          bfield_q    <= '0;
          hcrc_q      <= Crc16Init;
          bcrc_q      <= Crc32cInit;
          out_valid_q <= 1'b1;
        end else begin
          magic_ok_q <= magic_ok_d;
          len_q      <= len_d;
          hfield_q   <= hfield_d;
          bfield_q   <= bfield_d;
          hcrc_q     <= hcrc_d;
          bcrc_q     <= bcrc_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && cmd_i.is_end) begin
      status_q <= verdict;
      olen_q   <= (verdict == ST_OK) ? len_d : 16'd0;
      ostart_q <= (verdict == ST_OK) ? 4'(PrefixBytes) : 4'd0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = status_q;
  assign out_len_o    = olen_q;
  assign out_start_o  = ostart_q;

endmodule

@@ verif/fpv_checker.sv @@
// Checker for the prefix validator: predicts each datagram verdict and compares it on the output.
`timescale 1ns / 1ps
package fpv_tb_pkg;

  localparam int unsigned PrefixLen        = 12;
  localparam int unsigned MagicLen         = 4;
  localparam int unsigned HdrCrcLen        = 6;
  localparam logic [15:0] Ccitt16Poly      = 16'h1021;
  localparam logic [15:0] Ccitt16Seed      = 16'hFFFF;
  localparam logic [31:0] Castagnoli32Poly = 32'h82F6_3B78;
  localparam logic [31:0] Castagnoli32Seed = 32'hFFFF_FFFF;

  // MSB first, one data bit per pass
  function automatic logic [15:0] ccitt16_next(logic [15:0] crc, logic [7:0] b);
    logic fb;
    int   i;
    for (i = 7; i >= 0; i--) begin
      fb  = crc[15] ^ b[i];
      crc = {crc[14:0], 1'b0} ^ (fb ? Ccitt16Poly : 16'h0000);
    end
    return crc;
  endfunction

  // reflected, LSB first
  function automatic logic [31:0] castagnoli32_next(logic [31:0] crc, logic [7:0] b);
    logic fb;
    int   i;
    for (i = 0; i < 8; i++) begin
      fb  = crc[0] ^ b[i];
      crc = {1'b0, crc[31:1]} ^ (fb ? Castagnoli32Poly : 32'h0);
    end
    return crc;
  endfunction

endpackage

module fpv_checker
  import fpv_pkg::*;
  import fpv_tb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  output int          fail_count,
  output int          verdicts_pending
);

  typedef struct packed {
    status_e     status;
    logic [15:0] blen;
    logic [3:0]  body_off;
  } verdict_t;

  typedef struct packed {
    logic [16:0] count;
    logic        magic_ok;
    logic [15:0] len_fld;
    logic [15:0] hcrc_fld;
    logic [31:0] bcrc_fld;
    logic [15:0] hcrc;
    logic [31:0] bcrc;
  } datagram_t;

  logic [31:0] magic_cfg;
  datagram_t   dgram;
  verdict_t    verdicts[$];

  function automatic datagram_t fresh_datagram();
    datagram_t d;
    d          = '0;
    d.magic_ok = 1'b1;
    d.hcrc     = Ccitt16Seed;
    d.bcrc     = Castagnoli32Seed;
    return d;
  endfunction

  function automatic datagram_t absorb_byte(datagram_t d, logic [7:0] b, logic [31:0] magic);
    int unsigned n;
    n = d.count;
    if (n < MagicLen && b != magic[8*n +: 8]) d.magic_ok = 1'b0;
    if (n < HdrCrcLen) d.hcrc = ccitt16_next(d.hcrc, b);
    if (n == 4) begin
      d.len_fld[7:0] = b;
    end else if (n == 5) begin
      d.len_fld[15:8] = b;
    end else if (n == 6) begin
      d.hcrc_fld[7:0] = b;
    end else if (n == 7) begin
      d.hcrc_fld[15:8] = b;
    end else if (n >= 8 && n < PrefixLen) begin
      d.bcrc_fld[8*(n-8) +: 8] = b;
    end else if (n >= PrefixLen && n - PrefixLen < d.len_fld) begin
      d.bcrc = castagnoli32_next(d.bcrc, b);
    end
    if (d.count != '1) d.count = d.count + 1'b1;
    return d;
  endfunction

  function automatic verdict_t judge_datagram(datagram_t d);
    verdict_t v;
    v = '0;
    if (d.count < PrefixLen || !d.magic_ok) begin
      v.status = ST_BAD_MAGIC;
    end else if (d.hcrc != d.hcrc_fld) begin
      v.status = ST_BAD_HCRC;
    end else if (PrefixLen + d.len_fld > d.count) begin
      v.status = ST_LEN_OOB;
    end else if (~d.bcrc != d.bcrc_fld) begin
      v.status = ST_BAD_BCRC;
    end else begin
      v.status   = ST_OK;
      v.blen     = d.len_fld;
      v.body_off = 4'(PrefixLen);
    end
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      magic_cfg = '0;
      dgram     = fresh_datagram();
      verdicts.delete();
      fail_count = 0;
    end else begin
      if (cfg_we_i) magic_cfg = cfg_wdata_i;
      if (s_tvalid && s_tready) begin
        if (!s_tuser) dgram = absorb_byte(dgram, s_tdata, magic_cfg);
        if (s_tuser || s_tlast) begin
          verdicts.push_back(judge_datagram(dgram));
          dgram = fresh_datagram();
        end
      end
      if (m_tvalid && m_tready) begin
        if (verdicts.size() == 0) begin
          $display("%0t: verdict %h with none expected", $time, m_tdata);
          fail_count++;
        end else begin
          want = verdicts.pop_front();
          if (m_tdata[2:0] != want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, m_tdata[2:0]);
            fail_count++;
          end
          if (m_tdata[18:3] != want.blen) begin
            $display("%0t: body_length expected %0d got %0d", $time, want.blen,
                     m_tdata[18:3]);
            fail_count++;
          end
          if (m_tdata[22:19] != want.body_off) begin
            $display("%0t: body_start expected %0d got %0d", $time, want.body_off,
                     m_tdata[22:19]);
            fail_count++;
          end
        end
      end
    end
    verdicts_pending = verdicts.size();
  end

endmodule

@@ verif/tb_top.sv @@
// Testbench top: drives datagram words and the magic register into the prefix validator.
`timescale 1ns / 1ps
module tb_top;
  import fpv_pkg::*;
  import fpv_tb_pkg::*;

  localparam int HoldCycles = 60;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;

  int         fail_count;
  int         verdicts_pending;
  int         snd_idle;
  int         rcv_idle;
  bit         hold_req;
  int         words_sent;
  int         frames_sent;
  logic [7:0] frame_bytes[$];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  frame_prefix_validator_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  fpv_checker u_chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .s_tvalid         (s_axis_tvalid),
    .s_tready         (s_axis_tready),
    .s_tdata          (s_axis_tdata),
    .s_tlast          (s_axis_tlast),
    .s_tuser          (s_axis_tuser),
    .m_tvalid         (m_axis_tvalid),
    .m_tready         (m_axis_tready),
    .m_tdata          (m_axis_tdata),
    .fail_count       (fail_count),
    .verdicts_pending (verdicts_pending)
  );

  // sink side: random back-pressure, or a long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req      = 1'b0;
        m_axis_tready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      m_axis_tready = ($urandom_range(99) >= rcv_idle);
    end
  end

  initial begin
    #400_000;
    $display("tb_top NOT OK");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_word(input logic [7:0] data, input logic last, input logic marker);
    if ($urandom_range(99) < snd_idle) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = data;
    s_axis_tlast  = last;
    s_axis_tuser  = marker;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    words_sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (verdicts_pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_magic(input logic [31:0] value);
    cfg_wdata_i = value;
    cfg_we_i    = 1'b1;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  function automatic void make_datagram(input logic [31:0] magic, input int unsigned len,
                                        input int unsigned trail);
    logic [15:0] hcrc;
    logic [31:0] bcrc;
    logic [7:0]  b;
    int          i;
    frame_bytes.delete();
    for (i = 0; i < 4; i++) frame_bytes.push_back(magic[8*i +: 8]);
    frame_bytes.push_back(len[7:0]);
    frame_bytes.push_back(len[15:8]);
    hcrc = Ccitt16Seed;
    for (i = 0; i < 6; i++) hcrc = ccitt16_next(hcrc, frame_bytes[i]);
    frame_bytes.push_back(hcrc[7:0]);
    frame_bytes.push_back(hcrc[15:8]);
    repeat (4) frame_bytes.push_back(8'h00);
    bcrc = Castagnoli32Seed;
    for (i = 0; i < len; i++) begin
      b    = 8'($urandom_range(255));
      bcrc = castagnoli32_next(bcrc, b);
      frame_bytes.push_back(b);
    end
    bcrc = ~bcrc;
    for (i = 0; i < 4; i++) frame_bytes[8+i] = bcrc[8*i +: 8];
    repeat (trail) frame_bytes.push_back(8'($urandom_range(255)));
  endfunction

  function automatic void flip_bit(input int idx);
    frame_bytes[idx] = frame_bytes[idx] ^ (8'h01 << $urandom_range(7));
  endfunction

  function automatic void truncate(input int keep);
    while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
  endfunction

  task automatic send_frame(input bit by_marker);
    int i;
    if (frame_bytes.size() == 0) by_marker = 1'b1;
    for (i = 0; i < frame_bytes.size(); i++) begin
      send_word(frame_bytes[i], !by_marker && i == frame_bytes.size() - 1, 1'b0);
    end
    if (by_marker) send_word(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
    frames_sent++;
  endtask

  task automatic random_frame(input logic [31:0] magic);
    int kind;
    int len;
    bit by_marker;
    kind = $urandom_range(99);
    len  = ($urandom_range(19) == 0) ? $urandom_range(64, 32) : $urandom_range(8);
    if (kind >= 58 && kind < 66 && len == 0) len = 1;
    make_datagram(magic, len, ($urandom_range(2) == 0) ? $urandom_range(1, 3) : 0);
    by_marker = ($urandom_range(4) == 0);
    if (kind < 40) begin
      // well-formed
    end else if (kind < 50) begin
      flip_bit($urandom_range(3));
    end else if (kind < 58) begin
      flip_bit($urandom_range(7, 4));
    end else if (kind < 66) begin
      truncate(PrefixLen + len - $urandom_range(1, len));
    end else if (kind < 74) begin
      flip_bit($urandom_range(8, 11 + len));
    end else if (kind < 82) begin
      truncate($urandom_range(11));
    end else if (kind < 90) begin
      by_marker = 1'b1;
    end else begin
      frame_bytes.delete();
      repeat ($urandom_range(1, 30)) frame_bytes.push_back(8'($urandom_range(255)));
    end
    send_frame(by_marker);
  endtask

  task automatic random_phase(input int words, input logic [31:0] magic);
    int w0;
    int f0;
    w0 = words_sent;
    f0 = frames_sent;
    while (words_sent - w0 < words || frames_sent - f0 < 10) random_frame(magic);
  endtask

  initial begin
    logic [31:0] magic;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    s_axis_tuser  = 1'b0;
    hold_req      = 1'b0;
    snd_idle      = 13;
    rcv_idle      = 46;
    words_sent    = 0;
    frames_sent   = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: magic still at its reset value
    send_word(8'hFF, 1'b1, 1'b1);
    send_word(8'h00, 1'b1, 1'b0);
    make_datagram(32'h0, 0, 0);
    send_frame(1'b1);
    wait_idle();
    write_magic(32'hFFFF_FFFF);
    make_datagram(32'hFFFF_FFFF, 1, 1);
    send_frame(1'b0);
    wait_idle();

    // sink stalls while markers keep coming: queue fills, input stalls
    snd_idle = 0;
    hold_req = 1'b1;
    repeat (12) send_word(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
    make_datagram(32'hFFFF_FFFF, 2, 0);
    send_frame(1'b0);
    wait_idle();

    snd_idle = 13;
    rcv_idle = 46;
    magic    = $urandom;
    write_magic(magic);
    random_phase(190, magic);
    wait_idle();

    snd_idle = 46;
    rcv_idle = 13;
    magic    = $urandom;
    write_magic(magic);
    random_phase(190, magic);
    wait_idle();

    snd_idle = 0;
    rcv_idle = 0;
    write_magic(32'h0);
    random_phase(190, 32'h0);
    wait_idle();

    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
